// ===== src/psbf_pkg.sv =====
package psbf_pkg;

  localparam int ChanW   = 8;
  localparam int LevelW  = 8;
  localparam int RouteW  = 6;
  localparam int ChipW   = 2;
  localparam int PinW    = 4;
  localparam int DutyW   = 12;
  localparam int OpW     = 2;
  localparam int SDataW  = 24;
  localparam int MDataW  = 32;

  typedef enum logic [OpW-1:0] {
    OP_SET     = 2'd0,
    OP_SET_ALL = 2'd1,
    OP_READ    = 2'd2,
    OP_FLUSH   = 2'd3
  } op_e;

  typedef struct packed {
    logic              is_read;
    logic [LevelW-1:0] read_value;
    logic [ChipW-1:0]  chip_select;
    logic [PinW-1:0]   chip_channel;
    logic [DutyW-1:0]  duty;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [ChipW-1:0] chip;
    logic [PinW-1:0]  pin;
  } route_t;

  // level*4095/255 = 16*level + level/17; level/17 is (level*241) >> 12 for 8-bit levels
  function automatic logic [DutyW-1:0] duty_of(logic [LevelW-1:0] lvl);
    logic [15:0] prod;
    prod = {8'h00, lvl} * 16'd241;
    duty_of = {lvl, 4'h0} + {8'h00, prod[15:12]};
  endfunction

  function automatic route_t route_of(logic [RouteW-1:0] ch);
    route_t r;
    if (ch < 6'd8) begin
      r.chip = 2'd0;
      r.pin  = {1'b1, ch[2:0]};
    end else if (ch < 6'd16) begin
      r.chip = 2'd1;
      r.pin  = {1'b0, ch[2:0]};
    end else if (ch < 6'd24) begin
      r.chip = 2'd2;
      r.pin  = {1'b0, ch[2:0]};
    end else if (ch < 6'd32) begin
      r.chip = 2'd1;
      r.pin  = {1'b1, ch[2:0]};
    end else if (ch < 6'd40) begin
      r.chip = 2'd0;
      r.pin  = {1'b0, ch[2:0]};
    end else begin
      r.chip = 2'd2;
      r.pin  = ch[3:0];
    end
    route_of = r;
  endfunction

endpackage

// ===== src/pwm_shadow_buffer_flush_core.sv =====
// PWM shadow buffer: holds NUM_CHANNELS 8-bit levels and the levels last sent to three
// driver chips, both in single-port-read memories with registered read data. Set and
// set-all leave the input open; a read does one memory read, then the answer goes
// to the output register. An update walks the channels at one per cycle, unless the
// output side stalls, through the memories' read port and keeps the input closed for the
// whole update; each changed (or, with force_all, every) channel gives one driver write
// with duty = level*4095/255, and the final write carries tlast. Reset
// takes effect at once: per-entry valid bits make unwritten entries read as zero, so no
// clearing pass is needed.
module pwm_shadow_buffer_flush_core
  import psbf_pkg::*;
#(
  parameter int NUM_CHANNELS = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [SDataW-1:0] s_axis_tdata,  // channel[7:0], level[15:8], force_all[16]
  input  logic [OpW-1:0]    s_axis_tuser,  // op[1:0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [MDataW-1:0] m_axis_tdata,  // read_value[7:0], chip_select[9:8],
                                           // chip_channel[13:10], duty[25:14]
  output logic              m_axis_tuser,  // is_read[0]
  output logic              m_axis_tlast
);

  localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CW = $clog2(NUM_CHANNELS + 1);
  localparam logic [IW-1:0]    LastIdx = IW'(NUM_CHANNELS - 1);
  localparam logic [CW-1:0]    NumCh   = CW'(NUM_CHANNELS);
  localparam logic [ChanW-1:0] NumChIn = ChanW'(NUM_CHANNELS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [LevelW-1:0] cur_mem [NUM_CHANNELS];
  logic [LevelW-1:0] snt_mem [NUM_CHANNELS];
  logic [LevelW-1:0] cur_rd_q, snt_rd_q;
  logic              cur_vld_rd_q, snt_vld_rd_q;
  logic [NUM_CHANNELS-1:0] cur_vld_q, cur_vld_d, snt_vld_q, snt_vld_d;

  logic [LevelW-1:0] all_level_q, all_level_d;
  logic [CW-1:0]     iss_q, iss_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IW-1:0]     chk_idx_q, chk_idx_d;
  logic [IW-1:0]     rd_idx_q, rd_idx_d;
  logic              rd_inr_q, rd_inr_d;
  logic              force_q, force_d;
  result_t           cand_q, cand_d, out_q, out_d, new_wr;
  logic              cand_vld_q, cand_vld_d, out_vld_q, out_vld_d;

  op_e               in_op;
  logic [ChanW-1:0]  in_chan;
  logic [LevelW-1:0] in_level;
  logic              in_force, in_range, s_fire;

  logic [IW-1:0]     rd_addr;
  logic [LevelW-1:0] cur_lvl, snt_lvl;
  logic              out_free, emit, stall, cur_we, snt_we;
  route_t            rt;

  assign in_op    = op_e'(s_axis_tuser);
  assign in_chan  = s_axis_tdata[7:0];
  assign in_level = s_axis_tdata[15:8];
  assign in_force = s_axis_tdata[16];
  assign in_range = in_chan < NumChIn;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign cur_lvl  = cur_vld_rd_q ? cur_rd_q : all_level_q;
  assign snt_lvl  = snt_vld_rd_q ? snt_rd_q : '0;
  assign out_free = !out_vld_q || m_axis_tready;
  assign emit     = (state_q == S_SCAN) && chk_vld_q && (force_q || (cur_lvl != snt_lvl));
  // hold the scan while a second write is found with the output still full
  assign stall    = emit && cand_vld_q && !out_free;
  assign cur_we   = s_fire && (in_op == OP_SET) && in_range;
  assign snt_we   = emit && !stall;

  assign rt = route_of(RouteW'(chk_idx_q));

  always_comb begin
    new_wr              = '0;
    new_wr.chip_select  = rt.chip;
    new_wr.chip_channel = rt.pin;
    new_wr.duty         = duty_of(cur_lvl);
  end

  always_comb begin
    case (state_q)
      S_IDLE:  rd_addr = in_chan[IW-1:0];
      S_READ:  rd_addr = rd_idx_q;
      S_SCAN:  rd_addr = stall ? chk_idx_q : iss_q[IW-1:0];
      default: rd_addr = chk_idx_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[in_chan[IW-1:0]] <= in_level;
    end
    cur_rd_q <= cur_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (snt_we) begin
      snt_mem[chk_idx_q] <= cur_lvl;
    end
    snt_rd_q <= snt_mem[rd_addr];
  end

  always_comb begin
    cur_vld_d = cur_vld_q;
    snt_vld_d = snt_vld_q;
    if (s_fire && (in_op == OP_SET_ALL)) begin
      cur_vld_d = '0;
    end else if (cur_we) begin
      cur_vld_d[in_chan[IW-1:0]] = 1'b1;
    end
    if (snt_we) begin
      snt_vld_d[chk_idx_q] = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    all_level_d = all_level_q;
    iss_d       = iss_q;
    chk_vld_d   = chk_vld_q;
    chk_idx_d   = chk_idx_q;
    rd_idx_d    = rd_idx_q;
    rd_inr_d    = rd_inr_q;
    force_d     = force_q;
    cand_d      = cand_q;
    cand_vld_d  = cand_vld_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q;

    if (m_axis_tvalid && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          case (in_op)
            OP_SET_ALL: begin
              all_level_d = in_level;
            end
            OP_READ: begin
              rd_idx_d = in_chan[IW-1:0];
              rd_inr_d = in_range;
              state_d  = S_READ;
            end
            OP_FLUSH: begin
              force_d    = in_force;
              iss_d      = '0;
              chk_vld_d  = 1'b0;
              cand_vld_d = 1'b0;
              state_d    = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          out_d            = '0;
          out_d.is_read    = 1'b1;
          out_d.read_value = rd_inr_q ? cur_lvl : '0;
          out_d.last       = 1'b1;
          out_vld_d        = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!stall) begin
          chk_vld_d = (iss_q < NumCh);
          chk_idx_d = iss_q[IW-1:0];
          if (iss_q < NumCh) begin
            iss_d = iss_q + CW'(1);
          end
          // keep one write back so the final one can be marked
          if (emit) begin
            if (cand_vld_q) begin
              out_d     = cand_q;
              out_vld_d = 1'b1;
            end
            cand_d     = new_wr;
            cand_vld_d = 1'b1;
          end
          if (chk_vld_q && (chk_idx_q == LastIdx)) begin
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (!cand_vld_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d      = cand_q;
          out_d.last = 1'b1;
          out_vld_d  = 1'b1;
          cand_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_vld_q    <= '0;
      snt_vld_q    <= '0;
      cur_vld_rd_q <= 1'b0;
      snt_vld_rd_q <= 1'b0;
      all_level_q  <= '0;
      iss_q        <= '0;
      chk_vld_q    <= 1'b0;
      cand_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_vld_q    <= cur_vld_d;
      snt_vld_q    <= snt_vld_d;
      cur_vld_rd_q <= cur_vld_q[rd_addr];
      snt_vld_rd_q <= snt_vld_q[rd_addr];
      all_level_q  <= all_level_d;
      iss_q        <= iss_d;
      chk_vld_q    <= chk_vld_d;
      cand_vld_q   <= cand_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    rd_idx_q  <= rd_idx_d;
    rd_inr_q  <= rd_inr_d;
    force_q   <= force_d;
    cand_q    <= cand_d;
    out_q     <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_q.duty, out_q.chip_channel, out_q.chip_select,
                          out_q.read_value};
  assign m_axis_tuser  = out_q.is_read;
  assign m_axis_tlast  = out_q.last;

endmodule

// ===== src/psbf_checker.sv =====
module psbf_checker
  import psbf_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [OpW-1:0]    s_axis_tuser,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [MDataW-1:0] m_axis_tdata,
  input logic              m_axis_tuser,
  input logic              m_axis_tlast
);

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[25:8] == '0))
    else $error("read answer without tlast or with driver fields set");

  a_write_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[7:0] == '0))
    else $error("driver write carries a read value");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser == OP_READ || s_axis_tuser == OP_FLUSH) |=> !s_axis_tready)
    else $error("input open directly after read or update");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31:26] == '0))
    else $error("padding bits of output item not zero");

endmodule

bind pwm_shadow_buffer_flush_core psbf_checker u_psbf_checker (.*);
